[design/ffba_pkg.sv]
// Shared constants and types for the first-fit block allocator.
`timescale 1ns / 1ps
`default_nettype none

package ffba_pkg;

  localparam int unsigned MAX_BLOCKS_DEF = 16;
  localparam int unsigned SIZE_BITS_DEF  = 16;

  localparam int unsigned CFG_W   = 5;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned NUM_W   = 5;
  localparam int unsigned FIELD_W = 16;

  localparam logic [CFG_W-1:0] BLOCKS_RESET = 5'd16;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_REQ  = 1'b1;

  // Control part of a beat as it travels down the cell row
  typedef struct packed {
    logic             valid;
    logic             cmd;
    logic [IDX_W-1:0] idx;
    logic             found;
    logic [NUM_W-1:0] number;
  } item_ctrl_t;

endpackage

`default_nettype wire

[design/ffba_cell.sv]
// One block cell: holds a block size and its taken flag, passes beats on.
`timescale 1ns / 1ps
`default_nettype none

module ffba_cell #(
  parameter int unsigned CELL_ID   = 0,
  parameter int unsigned SIZE_BITS = ffba_pkg::SIZE_BITS_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       advance_i,
  input  wire logic [ffba_pkg::CFG_W-1:0] blocks_in_use_i,
  input  wire ffba_pkg::item_ctrl_t       ctrl_i,
  input  wire logic [SIZE_BITS-1:0]       val_i,
  input  wire logic [SIZE_BITS-1:0]       bsize_i,
  output ffba_pkg::item_ctrl_t            ctrl_o,
  output logic [SIZE_BITS-1:0]            val_o,
  output logic [SIZE_BITS-1:0]            bsize_o
);

  logic [SIZE_BITS-1:0] size_q;
  logic                 taken_q, taken_d;
  logic                 in_range, hit_load, claim;
  ffba_pkg::item_ctrl_t ctrl_q, ctrl_d;
  logic [SIZE_BITS-1:0] val_q, bsize_q, bsize_d;

  always_comb begin
    in_range = 32'(blocks_in_use_i) > CELL_ID;
    hit_load = ctrl_i.valid && (ctrl_i.cmd == ffba_pkg::CMD_LOAD) &&
               (32'(ctrl_i.idx) == CELL_ID);
    claim    = ctrl_i.valid && (ctrl_i.cmd == ffba_pkg::CMD_REQ) && !ctrl_i.found &&
               !taken_q && in_range && (size_q >= val_i);

    taken_d = taken_q;
    if (hit_load) begin
      taken_d = 1'b0;
    end else if (claim) begin
      taken_d = 1'b1;
    end

    ctrl_d  = ctrl_i;
    bsize_d = bsize_i;
    if (claim) begin
      ctrl_d.found  = 1'b1;
      ctrl_d.number = ffba_pkg::NUM_W'(CELL_ID + 1);
      bsize_d       = size_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taken_q <= 1'b0;
      ctrl_q  <= '0;
    end else if (advance_i) begin
      taken_q <= taken_d;
      ctrl_q  <= ctrl_d;
    end
  end

  // Size store and beat payload carry no reset
  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      if (hit_load) begin
        size_q <= val_i;
      end
      val_q   <= val_i;
      bsize_q <= bsize_d;
    end
  end

  assign ctrl_o  = ctrl_q;
  assign val_o   = val_q;
  assign bsize_o = bsize_q;

endmodule

`default_nettype wire

[design/first_fit_block_allocator.sv]
// Top level of the first-fit block allocator: cell row, output register, config.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries command, block_index and
//   size_value. A load beat (command 0) writes one block's size and frees it;
//   it yields no result. A request beat (command 1) takes the lowest-numbered
//   free block in use that is large enough and yields one result beat.
//   Output channel (out_valid_o / out_stall_i) carries found, block_number,
//   block_size and fragment; all are zero when nothing fits.
//   Config channel (cfg_valid_i / cfg_ready_o) writes blocks_in_use; write it
//   only while no beat is in flight.
// Timing:
//   Every beat walks a row of MAX_BLOCKS cells, one cell per cycle while the
//   row advances, then the output register. A new beat may enter every cycle
//   unless in_stall_o is raised; later requests see flags claimed by earlier.
// Reset and stall:
//   Reset frees all blocks, empties the row and sets blocks_in_use to 16.
//   Sizes are undefined until loaded. While a result waits under out_stall_i
//   the whole row holds and in_stall_o is raised.
`timescale 1ns / 1ps
`default_nettype none

module first_fit_block_allocator #(
  parameter int unsigned MAX_BLOCKS = ffba_pkg::MAX_BLOCKS_DEF,
  parameter int unsigned SIZE_BITS  = ffba_pkg::SIZE_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [ffba_pkg::CFG_W-1:0]   cfg_data_i,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic                         command_i,
  input  wire logic [ffba_pkg::IDX_W-1:0]   block_index_i,
  input  wire logic [ffba_pkg::FIELD_W-1:0] size_value_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic                              found_o,
  output logic [ffba_pkg::NUM_W-1:0]        block_number_o,
  output logic [ffba_pkg::FIELD_W-1:0]      block_size_o,
  output logic [ffba_pkg::FIELD_W-1:0]      fragment_o
);

  logic [ffba_pkg::CFG_W-1:0] blocks_in_use_q;
  logic                       advance;

  ffba_pkg::item_ctrl_t ctrl  [0:MAX_BLOCKS];
  logic [SIZE_BITS-1:0] val   [0:MAX_BLOCKS];
  logic [SIZE_BITS-1:0] bsize [0:MAX_BLOCKS];

  logic                         out_valid_q;
  logic                         found_q;
  logic [ffba_pkg::NUM_W-1:0]   number_q;
  logic [ffba_pkg::FIELD_W-1:0] bsize_q, frag_q;
  logic [SIZE_BITS-1:0]         frag;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blocks_in_use_q <= ffba_pkg::BLOCKS_RESET;
    end else if (cfg_valid_i) begin
      blocks_in_use_q <= cfg_data_i;
    end
  end

  // Hold the whole row while a finished result is not taken
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = !advance;

  always_comb begin
    ctrl[0]        = '0;
    ctrl[0].valid  = in_valid_i;
    ctrl[0].cmd    = command_i;
    ctrl[0].idx    = block_index_i;
    val[0]         = SIZE_BITS'(size_value_i);
    bsize[0]       = '0;
  end

  for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
    ffba_cell #(
      .CELL_ID  (g),
      .SIZE_BITS(SIZE_BITS)
    ) u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .advance_i      (advance),
      .blocks_in_use_i(blocks_in_use_q),
      .ctrl_i         (ctrl[g]),
      .val_i          (val[g]),
      .bsize_i        (bsize[g]),
      .ctrl_o         (ctrl[g+1]),
      .val_o          (val[g+1]),
      .bsize_o        (bsize[g+1])
    );
  end

  assign frag = ctrl[MAX_BLOCKS].found ? (bsize[MAX_BLOCKS] - val[MAX_BLOCKS]) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= ctrl[MAX_BLOCKS].valid && (ctrl[MAX_BLOCKS].cmd == ffba_pkg::CMD_REQ);
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      found_q  <= ctrl[MAX_BLOCKS].found;
      number_q <= ctrl[MAX_BLOCKS].number;
      bsize_q  <= ffba_pkg::FIELD_W'(bsize[MAX_BLOCKS]);
      frag_q   <= ffba_pkg::FIELD_W'(frag);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign found_o        = found_q;
  assign block_number_o = number_q;
  assign block_size_o   = bsize_q;
  assign fragment_o     = frag_q;

  // A miss reports zeros in every field
  a_miss_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> block_number_o == '0 && block_size_o == '0 &&
                                fragment_o == '0)
    else $error("miss result carries non-zero fields");

  // A hit names a block inside the searched range
  a_hit_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o && (MAX_BLOCKS < 32) |->
      block_number_o != '0 && block_number_o <= blocks_in_use_q &&
      32'(block_number_o) <= MAX_BLOCKS)
    else $error("hit block number outside searched range");

  // The row only stalls behind a waiting result
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a waiting result");

endmodule

`default_nettype wire
